@@ sv/lppr_pkg.sv @@
package lppr_pkg;

  localparam int unsigned MaxWidthDefault = 4096;
  localparam int unsigned SampleBits      = 8;
  localparam int unsigned ResBits         = 10;
  localparam int unsigned SumBits         = 21;
  localparam int unsigned GolBits         = 9;
  localparam int unsigned RwBits          = 13;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [3:0] PredAvg    = 4'd0;
  localparam logic [3:0] PredLeft   = 4'd1;
  localparam logic [3:0] PredAbove  = 4'd2;
  localparam logic [3:0] PredUl     = 4'd3;
  localparam logic [3:0] PredPlanar = 4'd4;
  localparam logic [3:0] PredPlA    = 4'd5;
  localparam logic [3:0] PredPlB    = 4'd6;
  localparam logic [3:0] PredMean   = 4'd7;
  localparam logic [3:0] PredMed    = 4'd8;

  localparam logic CfgPredMode = 1'b0;
  localparam logic CfgRowWidth = 1'b1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic signed [ResBits-1:0] res_l;
    logic signed [ResBits-1:0] res_b;
    logic signed [ResBits-1:0] res_r;
    logic                      row_end;
    logic [SumBits-1:0]        sum_l;
    logic [SumBits-1:0]        sum_b;
    logic [SumBits-1:0]        sum_r;
    logic [RwBits-1:0]         width;
  } lppr_item_t;

  function automatic logic signed [10:0] lppr_pred(input logic signed [10:0] a,
                                                   input logic signed [10:0] b,
                                                   input logic signed [10:0] c,
                                                   input logic [3:0] mode);
    logic signed [10:0] lo;
    logic signed [10:0] hi;
    logic signed [10:0] s3;
    logic signed [10:0] d;
    logic signed [10:0] p;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    s3 = a + b + c;
    p  = '0;
    case (mode)
      PredAvg:    p = 11'((20'(s3[9:0]) * 20'd683) >> 11);
      PredLeft:   p = a;
      PredAbove:  p = b;
      PredUl:     p = c;
      PredPlanar: p = a + b - c;
      PredPlA: begin
        d = b - c;
        p = a + ((d + $signed({10'd0, d[10]})) >>> 1);
      end
      PredPlB: begin
        d = a - c;
        p = b + ((d + $signed({10'd0, d[10]})) >>> 1);
      end
      PredMean:   p = (a + b) >>> 1;
      PredMed: begin
        if (c >= hi) p = lo;
        else if (c <= lo) p = hi;
        else p = a + b - c;
      end
      default:    p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/lppr_front.sv @@
module lppr_front #(
  parameter int unsigned MAX_WIDTH = lppr_pkg::MaxWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              luma,
  input  logic [7:0]              chroma_blue,
  input  logic [7:0]              chroma_red,
  input  logic                    frame_start,
  input  logic [3:0]              pred_mode,
  input  logic [lppr_pkg::RwBits-1:0] row_width,
  output logic                    push,
  output lppr_pkg::lppr_item_t    item
);
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SB = lppr_pkg::SumBits;

  logic [23:0] line_mem [MAX_WIDTH];
  logic [23:0] above;
  logic [CW-1:0] col, col_next;
  logic top;
  logic [23:0] left, ul;
  logic [SB-1:0] sums [3];

  logic       s1_v, s1_fs, s1_top;
  logic [23:0] s1_pix;
  logic [CW-1:0] s1_col;
  logic [lppr_pkg::RwBits-1:0] s1_w;

  logic [lppr_pkg::RwBits-1:0] wc;
  logic [CW:0] wmax;
  logic        fs_top;
  logic        last;
  logic [23:0] b_pix;
  logic signed [lppr_pkg::ResBits-1:0] r [3];
  logic [SB-1:0] s_new [3];

  always_comb begin
    wmax = (CW+1)'(MAX_WIDTH);
    if (row_width == '0) wc = lppr_pkg::RwBits'(1);
    else if (32'(row_width) > MAX_WIDTH) wc = lppr_pkg::RwBits'(MAX_WIDTH);
    else wc = row_width;
  end

  // stage 0: address the line store, column follows the item still in stage 1
  always_comb begin
    if (frame_start) col_next = '0;
    else if (s1_v) col_next = last ? '0 : s1_col + 1'b1;
    else col_next = col;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      above <= (s1_v && s1_col == col_next) ? s1_pix : line_mem[col_next];
    end
    if (s1_v) begin
      line_mem[s1_col] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= take;
    if (take) begin
      s1_pix <= {luma, chroma_blue, chroma_red};
      s1_fs  <= frame_start;
      s1_col <= col_next;
      s1_w   <= wc;
    end
  end

  assign last   = ({1'b0, s1_col} + 1'b1) >= (CW+1)'(s1_w) || s1_col == CW'(wmax - 1'b1);
  assign fs_top = s1_fs | top;
  // a write to the same column just before is forwarded (width one row)
  assign b_pix  = above;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [10:0] x, a, b, c, p;
      x = {3'b0, s1_pix[23-8*k -: 8]};
      a = {3'b0, left[23-8*k -: 8]};
      b = {3'b0, b_pix[23-8*k -: 8]};
      c = {3'b0, ul[23-8*k -: 8]};
      if (fs_top && s1_col == '0) p = '0;
      else if (fs_top) p = a;
      else if (s1_col == '0) p = b;
      else p = lppr_pkg::lppr_pred(a, b, c, pred_mode);
      r[k] = 10'(x - p);
      s_new[k] = (s1_fs ? '0 : sums[k]) +
                 SB'(r[k][9] ? 10'(-r[k]) : r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      top  <= 1'b1;
      left <= '0;
      ul   <= '0;
      for (int k = 0; k < 3; k++) sums[k] <= '0;
    end else if (s1_v) begin
      left <= s1_pix;
      ul   <= b_pix;
      for (int k = 0; k < 3; k++) sums[k] <= last ? '0 : s_new[k];
      col  <= last ? '0 : s1_col + 1'b1;
      top  <= last ? 1'b0 : fs_top;
    end else if (take && frame_start) begin
      col <= '0;
    end
  end

  assign push = s1_v;
  always_comb begin
    item.res_l   = r[0];
    item.res_b   = r[1];
    item.res_r   = r[2];
    item.row_end = last;
    item.sum_l   = s_new[0];
    item.sum_b   = s_new[1];
    item.sum_r   = s_new[2];
    item.width   = s1_w;
  end
endmodule

@@ sv/lppr_queue.sv @@
module lppr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lppr_pkg::lppr_item_t din,
  input  logic                 pop,
  output logic                 nonempty,
  output logic [2:0]           level,
  output lppr_pkg::lppr_item_t dout
);
  localparam int unsigned D = lppr_pkg::QueueDepth;
  lppr_pkg::lppr_item_t mem [D];
  logic [1:0] wp, rp;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; level <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      level <= level + 3'(push) - 3'(pop);
    end
    if (push) mem[wp] <= din;
  end
  assign nonempty = level != '0;
  assign dout = mem[rp];
endmodule

@@ sv/lppr_back.sv @@
module lppr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 avail,
  input  lppr_pkg::lppr_item_t item,
  output logic                 pop,
  input  logic                 stall,
  output logic                 valid,
  output logic signed [9:0]    res_luma,
  output logic signed [9:0]    res_blue,
  output logic signed [9:0]    res_red,
  output logic                 row_end,
  output logic [8:0]           golomb_luma,
  output logic [8:0]           golomb_blue,
  output logic [8:0]           golomb_red
);
  localparam int unsigned SB = lppr_pkg::SumBits;
  lppr_pkg::bk_state_t st, st_next;
  logic [SB-1:0] rem [3];
  logic [SB-1:0] quo [3];
  logic [4:0] step;
  logic out_free;

  assign out_free = !valid || !stall;

  always_comb begin
    st_next = st;
    case (st)
      lppr_pkg::BK_IDLE:
        if (avail && item.row_end) st_next = lppr_pkg::BK_DIV;
      lppr_pkg::BK_DIV:
        if (step == 5'(SB-1)) st_next = lppr_pkg::BK_OUT;
      lppr_pkg::BK_OUT:
        if (out_free) st_next = lppr_pkg::BK_IDLE;
      default: st_next = lppr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    case (st)
      lppr_pkg::BK_IDLE: pop = avail && !item.row_end && out_free;
      lppr_pkg::BK_OUT:  pop = out_free;
      default:           pop = 1'b0;
    endcase
  end

  // restoring divider, one quotient bit per cycle for all three channels
  always_ff @(posedge clk) begin
    if (st == lppr_pkg::BK_IDLE) begin
      step <= '0;
      rem[0] <= '0; rem[1] <= '0; rem[2] <= '0;
      quo[0] <= item.sum_l; quo[1] <= item.sum_b; quo[2] <= item.sum_r;
    end else if (st == lppr_pkg::BK_DIV) begin
      step <= step + 1'b1;
      for (int k = 0; k < 3; k++) begin
        logic [SB:0] t;
        t = {rem[k], quo[k][SB-1]};
        if (t >= (SB+1)'(item.width)) begin
          rem[k] <= SB'(t - (SB+1)'(item.width));
          quo[k] <= {quo[k][SB-2:0], 1'b1};
        end else begin
          rem[k] <= t[SB-1:0];
          quo[k] <= {quo[k][SB-2:0], 1'b0};
        end
      end
    end
  end

  function automatic logic [8:0] clampg(input logic [SB-1:0] u);
    if (u == '0) return 9'd1;
    if (u > SB'(511)) return 9'd511;
    return u[8:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (pop) valid <= 1'b1;
    else if (!stall) valid <= 1'b0;
    if (pop) begin
      res_luma <= item.res_l;
      res_blue <= item.res_b;
      res_red  <= item.res_r;
      row_end  <= item.row_end;
      golomb_luma <= item.row_end ? clampg(quo[0]) : '0;
      golomb_blue <= item.row_end ? clampg(quo[1]) : '0;
      golomb_red  <= item.row_end ? clampg(quo[2]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st <= lppr_pkg::BK_IDLE;
    else st <= st_next;
  end
endmodule

@@ sv/lossless_pixel_predictor_residual.sv @@
// channel | signals                                        | dir
// in      | valid, stall, luma, chroma_blue, chroma_red, frame_start | in/out stall
// out     | out_valid, out_stall, res_*, row_end, golomb_*  | out/in stall
// cfg     | cfg_we, cfg_index, cfg_data                     | in
// in the front an item is registered with its line store read, then predicted;
// plain pixels leave one per cycle through the back while it is neither stalled nor dividing
// a row-end item holds the back while it is loaded, while the bit-serial divider
// works out the three row means side by side, and until it is handed off
// reset clears counters, flags, sums and queue; the line store is not cleared
// input stall rises when the queue nears full, output stall only holds the back
module lossless_pixel_predictor_residual #(
  parameter int unsigned MAX_WIDTH = lppr_pkg::MaxWidthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  logic [7:0]         luma,
  input  logic [7:0]         chroma_blue,
  input  logic [7:0]         chroma_red,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [9:0]  res_luma,
  output logic signed [9:0]  res_blue,
  output logic signed [9:0]  res_red,
  output logic               row_end,
  output logic [8:0]         golomb_luma,
  output logic [8:0]         golomb_blue,
  output logic [8:0]         golomb_red,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);
  logic [3:0]  pred_mode;
  logic [12:0] row_width;
  logic take, push, pop, avail;
  logic [2:0] level;
  lppr_pkg::lppr_item_t f_item, q_item;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pred_mode <= lppr_pkg::PredMed;
      row_width <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        lppr_pkg::CfgPredMode: pred_mode <= cfg_data[3:0];
        lppr_pkg::CfgRowWidth: row_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // two items may be in flight in the front stage; keep room for them
  assign stall = level >= 3'd2;
  assign take  = valid && !stall;

  lppr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .take, .luma, .chroma_blue, .chroma_red, .frame_start,
    .pred_mode, .row_width, .push, .item(f_item)
  );

  lppr_queue u_queue (
    .clk, .rst, .push, .din(f_item), .pop, .nonempty(avail), .level, .dout(q_item)
  );

  lppr_back u_back (
    .clk, .rst, .avail, .item(q_item), .pop, .stall(out_stall), .valid(out_valid),
    .res_luma, .res_blue, .res_red, .row_end, .golomb_luma, .golomb_blue, .golomb_red
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= 3'd4) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail) else $error("pop from empty queue");
  a_golomb_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !row_end) |-> (golomb_luma == 9'd0)) else $error("golomb off row end");
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  logic              clk;
  logic              rst;
  logic              valid;
  logic              stall;
  logic [7:0]        luma;
  logic [7:0]        chroma_blue;
  logic [7:0]        chroma_red;
  logic              frame_start;
  logic              out_valid;
  logic              out_stall;
  logic signed [9:0] res_luma;
  logic signed [9:0] res_blue;
  logic signed [9:0] res_red;
  logic              row_end;
  logic [8:0]        golomb_luma;
  logic [8:0]        golomb_blue;
  logic [8:0]        golomb_red;
  logic              cfg_we;
  logic              cfg_index;
  logic [12:0]       cfg_data;

  lossless_pixel_predictor_residual u_dut (
    .clk         (clk),
    .rst         (rst),
    .valid       (valid),
    .stall       (stall),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res_luma    (res_luma),
    .res_blue    (res_blue),
    .res_red     (res_red),
    .row_end     (row_end),
    .golomb_luma (golomb_luma),
    .golomb_blue (golomb_blue),
    .golomb_red  (golomb_red),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // one expected residual item
  typedef struct {
    logic signed [9:0] res[3];
    logic              row_end;
    logic [8:0]        gol[3];
  } residual_t;

  residual_t residual_q[$];

  // shadow of the block state and its registers
  logic [7:0]  line_mem[lppr_pkg::MaxWidthDefault][3];
  logic [7:0]  left_px[3];
  logic [7:0]  upleft_px[3];
  int unsigned col_cnt;
  bit          top_row;
  logic [20:0] abs_acc[3];
  logic [3:0]  mode_reg;
  logic [12:0] width_reg;

  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int neighbour_pred(int a, int b, int c, logic [3:0] m);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (m)
      lppr_pkg::PredAvg:    return (a + b + c) / 3;
      lppr_pkg::PredLeft:   return a;
      lppr_pkg::PredAbove:  return b;
      lppr_pkg::PredUl:     return c;
      lppr_pkg::PredPlanar: return a + b - c;
      lppr_pkg::PredPlA:    return a + (b - c) / 2;
      lppr_pkg::PredPlB:    return b + (a - c) / 2;
      lppr_pkg::PredMean:   return (a + b) / 2;
      lppr_pkg::PredMed: begin
        // median edge detector
        if (c >= hi) return lo;
        if (c <= lo) return hi;
        return a + b - c;
      end
      default:    return 0;
    endcase
  endfunction

  // advance the shadow state by one pixel and give the residual item
  function automatic residual_t residual_of(logic [7:0] px[3], logic fs);
    residual_t   e;
    int unsigned w;
    int unsigned col;
    int          r;
    int          b;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > lppr_pkg::MaxWidthDefault) w = lppr_pkg::MaxWidthDefault;
    // frame start restarts the frame, even mid-row
    if (fs) begin
      col_cnt = 0;
      top_row = 1'b1;
      for (int k = 0; k < 3; k++) abs_acc[k] = '0;
    end
    col = col_cnt;
    if (col >= lppr_pkg::MaxWidthDefault) col = lppr_pkg::MaxWidthDefault - 1;
    for (int k = 0; k < 3; k++) begin
      b = line_mem[col][k];
      if (top_row && col == 0) r = px[k];
      else if (top_row) r = int'(px[k]) - int'(left_px[k]);
      else if (col == 0) r = int'(px[k]) - b;
      else r = int'(px[k]) - neighbour_pred(left_px[k], b, upleft_px[k], mode_reg);
      e.res[k] = r[9:0];
      abs_acc[k] = abs_acc[k] + 21'((r < 0) ? -r : r);
      upleft_px[k] = b[7:0];
      left_px[k] = px[k];
      line_mem[col][k] = px[k];
    end
    if (col + 1 >= w) begin
      e.row_end = 1'b1;
      for (int k = 0; k < 3; k++) begin
        int unsigned u;
        u = abs_acc[k] / w;
        if (u < 1) u = 1;
        if (u > 511) u = 511;
        e.gol[k] = u[8:0];
        abs_acc[k] = '0;
      end
      col_cnt = 0;
      top_row = 1'b0;
    end else begin
      e.row_end = 1'b0;
      for (int k = 0; k < 3; k++) e.gol[k] = '0;
      col_cnt = col + 1;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // result side: random stall, compare every accepted item with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (residual_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          residual_t e;
          e = residual_q.pop_front();
          if (res_luma !== e.res[0]) report_mismatch("res_luma", res_luma, e.res[0]);
          if (res_blue !== e.res[1]) report_mismatch("res_blue", res_blue, e.res[1]);
          if (res_red !== e.res[2]) report_mismatch("res_red", res_red, e.res[2]);
          if (row_end !== e.row_end) report_mismatch("row_end", row_end, e.row_end);
          if (golomb_luma !== e.gol[0]) report_mismatch("golomb_luma", golomb_luma, e.gol[0]);
          if (golomb_blue !== e.gol[1]) report_mismatch("golomb_blue", golomb_blue, e.gol[1]);
          if (golomb_red !== e.gol[2]) report_mismatch("golomb_red", golomb_red, e.gol[2]);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // send one pixel; valid stays high afterwards unless a gap is drawn
  task automatic send_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr, logic fs);
    logic [7:0] px[3];
    px[0] = y;
    px[1] = cb;
    px[2] = cr;
    valid       <= 1'b1;
    luma        <= y;
    chroma_blue <= cb;
    chroma_red  <= cr;
    frame_start <= fs;
    do @(posedge clk); while (stall);
    residual_q.insert(residual_q.size(), residual_of(px, fs));
    if ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every expected item has come back
  task automatic drain;
    valid <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(logic idx, logic [12:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lppr_pkg::CfgPredMode) mode_reg = val[3:0];
    else width_reg = val;
  endtask

  function automatic logic [7:0] rand_sample;
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // a frame of random pixels, first one flagged; rare restarts inside
  task automatic send_frame(int unsigned n, int unsigned restart_pct);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(rand_sample(), rand_sample(), rand_sample(),
                 (i == 0) || ($urandom_range(99) < restart_pct));
  endtask

  // reset defaults, first pixel without frame_start, sample extremes
  task automatic test_reset_extremes;
    // reset width is 640 wide; a partial top row only
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    write_reg(lppr_pkg::CfgRowWidth, 13'd3);
    write_reg(lppr_pkg::CfgPredMode, 13'(lppr_pkg::PredMed));
    // extremes in a small frame, median edge detector
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    drain();
  endtask

  // every predictor code, unused ones included
  task automatic test_pred_modes;
    for (int m = 0; m < 16; m++) begin
      write_reg(lppr_pkg::CfgPredMode, 13'(m));
      send_frame(6, 0);
    end
    drain();
  endtask

  // width 0 acts as 1, width above the line store acts as its size
  task automatic test_width_limits;
    write_reg(lppr_pkg::CfgRowWidth, 13'd0);
    send_frame(3, 0);
    write_reg(lppr_pkg::CfgRowWidth, 13'd8191);
    send_frame(5, 0);
    // shrink mid-row: the row ends at once since the column is past the width
    write_reg(lppr_pkg::CfgRowWidth, 13'd2);
    send_pixel(8'd40, 8'd41, 8'd42, 1'b0);
    send_pixel(8'd17, 8'd200, 8'd3, 1'b0);
    send_pixel(8'd90, 8'd1, 8'd250, 1'b0);
    drain();
  endtask

  // frame restart in the middle of a row, and a mid-row width shrink
  task automatic test_midrow_events;
    write_reg(lppr_pkg::CfgPredMode, 13'(lppr_pkg::PredMed));
    write_reg(lppr_pkg::CfgRowWidth, 13'd5);
    send_frame(8, 0);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b1);
    send_pixel(8'd129, 8'd65, 8'd31, 1'b0);
    drain();
    write_reg(lppr_pkg::CfgRowWidth, 13'd2);
    send_pixel(8'd5, 8'd6, 8'd7, 1'b0);
    send_pixel(8'd8, 8'd9, 8'd10, 1'b0);
    drain();
  endtask

  // random phases: mostly clean frames, some restarts inside
  task automatic test_random_frames(int unsigned n_items);
    int unsigned sent;
    int unsigned w;
    int unsigned n;
    sent = 0;
    while (sent < n_items) begin
      write_reg(lppr_pkg::CfgPredMode,
                13'(($urandom_range(9) == 0) ? $urandom_range(15, 9)
                                             : $urandom_range(8)));
      w = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      write_reg(lppr_pkg::CfgRowWidth, 13'(w));
      n = w * $urandom_range(4, 2) + $urandom_range(w);
      if (n > 60) n = 60;
      send_frame(n, 3);
      sent += n;
      // sender waits for the whole backlog now and then
      if ($urandom_range(3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst         = 1'b1;
    valid       = 1'b0;
    luma        = '0;
    chroma_blue = '0;
    chroma_red  = '0;
    frame_start = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = lppr_pkg::CfgPredMode;
    cfg_data    = '0;
    err_cnt     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < lppr_pkg::MaxWidthDefault; i++)
      for (int k = 0; k < 3; k++) line_mem[i][k] = '0;
    for (int k = 0; k < 3; k++) begin
      left_px[k]   = '0;
      upleft_px[k] = '0;
      abs_acc[k]   = '0;
    end
    col_cnt   = 0;
    top_row   = 1'b1;
    mode_reg  = lppr_pkg::PredMed;
    width_reg = 13'd640;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 48;
    test_reset_extremes();
    test_pred_modes();
    test_width_limits();
    test_midrow_events();
    test_random_frames(130);
    send_idle_pct = 48;
    recv_idle_pct = 21;
    test_random_frames(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(130);

    drain();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lppr_pkg.sv
sv/lppr_front.sv
sv/lppr_queue.sv
sv/lppr_back.sv
sv/lossless_pixel_predictor_residual.sv
tb/sv/testbench.sv
